// ----- rtl/core/lprp_pkg.sv -----
// Package for the length-prefixed record parser.
// Holds the item structs, field tags, error codes and parse phases.
// No dependencies.
package lprp_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_FORMAT_VERSION   = 2'd0;
  localparam logic [1:0] REG_DROP_CODE        = 2'd1;
  localparam logic [1:0] REG_CREATE_CODE      = 2'd2;
  localparam logic [1:0] REG_MAX_FIELD_LENGTH = 2'd3;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;

  // Field tags carried by each result.
  localparam logic [2:0] TAG_HEADER   = 3'd0;
  localparam logic [2:0] TAG_PREFIX   = 3'd1;
  localparam logic [2:0] TAG_PATH     = 3'd2;
  localparam logic [2:0] TAG_TRAILING = 3'd5;
  localparam logic [2:0] TAG_REJECTED = 3'd6;

  // Error codes reported on the last byte.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_SHORT      = 3'd1;
  localparam logic [2:0] ERR_VERSION    = 3'd2;
  localparam logic [2:0] ERR_INTENT     = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd5;
  localparam logic [2:0] ERR_EMPTY_PATH = 3'd6;

  // String fields in record order.
  localparam logic [1:0] FIELD_PATH  = 2'd0;
  localparam logic [1:0] FIELD_TABLE = 2'd2;

  // Last index of the four prefix bytes.
  localparam logic [1:0] PREFIX_LAST = 2'd3;

  typedef enum logic [5:0] {
    PH_VERSION = 6'b000001,
    PH_INTENT  = 6'b000010,
    PH_PREFIX  = 6'b000100,
    PH_BODY    = 6'b001000,
    PH_TRAIL   = 6'b010000,
    PH_REJECT  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       last_byte;
  } rec_item_t;

  typedef struct packed {
    logic [2:0] field_tag;
    logic [7:0] data_byte;
    logic       record_done;
    logic       record_ok;
    logic [2:0] error_code;
    logic       is_create;
  } res_item_t;

endpackage

// ----- rtl/core/lprp_core.sv -----
// Parse state and result logic of the length-prefixed record parser.
// Holds the configuration registers; one byte is parsed per accepted transfer.
// Depends on lprp_pkg.
module lprp_core import lprp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     accept,
  input  rec_item_t                item,
  output res_item_t                result
);

  logic [7:0]  expected_version;
  logic [7:0]  drop_code;
  logic [7:0]  create_code;
  logic [15:0] max_field_length;

  phase_t      phase, phase_next;
  logic [1:0]  field_index, field_index_next;
  logic [1:0]  prefix_count, prefix_count_next;
  logic        length_high, length_high_next;
  logic [15:0] length_low, length_low_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [2:0]  latched_error, latched_error_next;
  logic        path_was_empty, path_was_empty_next;
  logic        intent_create, intent_create_next;

  logic [2:0]  err;
  logic [2:0]  tag;
  logic [15:0] remaining_dec;
  logic        prefix_too_long;
  logic        prefix_zero;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
      drop_code        <= 8'd0;
      create_code      <= 8'd1;
      max_field_length <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMAT_VERSION:   expected_version <= cfg_data[7:0];
        REG_DROP_CODE:        drop_code        <= cfg_data[7:0];
        REG_CREATE_CODE:      create_code      <= cfg_data[7:0];
        REG_MAX_FIELD_LENGTH: max_field_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // The full length is the high flag over the low sixteen bits.
  always_comb begin
    phase_next           = phase;
    field_index_next     = field_index;
    prefix_count_next    = prefix_count;
    length_high_next     = length_high;
    length_low_next      = length_low;
    bytes_remaining_next = bytes_remaining;
    latched_error_next   = latched_error;
    path_was_empty_next  = path_was_empty;
    intent_create_next   = intent_create;
    err                  = ERR_NONE;
    tag                  = TAG_REJECTED;
    remaining_dec        = bytes_remaining - 16'd1;
    prefix_too_long      = 1'b0;
    prefix_zero          = 1'b0;

    case (phase)
      PH_VERSION: begin
        tag = TAG_HEADER;
        if (item.last_byte) begin
          err = ERR_SHORT;
        end else if (item.record_byte != expected_version) begin
          err = ERR_VERSION;
        end else begin
          phase_next = PH_INTENT;
        end
      end
      PH_INTENT: begin
        tag = TAG_HEADER;
        if (item.record_byte != drop_code && item.record_byte != create_code) begin
          err = ERR_INTENT;
        end else begin
          intent_create_next = (item.record_byte == create_code);
          field_index_next   = FIELD_PATH;
          phase_next         = PH_PREFIX;
          prefix_count_next  = 2'd0;
          length_high_next   = 1'b0;
          length_low_next    = 16'd0;
        end
      end
      PH_PREFIX: begin
        tag = TAG_PREFIX;
        // Shift the byte in; bytes pushed above bit 15 only matter as nonzero.
        length_high_next = length_high | (length_low[15:8] != 8'd0);
        length_low_next  = {length_low[7:0], item.record_byte};
        if (prefix_count == PREFIX_LAST) begin
          prefix_too_long = length_high_next || (length_low_next > max_field_length);
          prefix_zero     = !length_high_next && (length_low_next == 16'd0);
          if (prefix_too_long) begin
            err = ERR_TOO_LONG;
          end else if (prefix_zero) begin
            if (field_index == FIELD_PATH) begin
              path_was_empty_next = 1'b1;
            end
            if (field_index >= FIELD_TABLE) begin
              phase_next = PH_TRAIL;
            end else begin
              field_index_next  = field_index + 2'd1;
              phase_next        = PH_PREFIX;
              prefix_count_next = 2'd0;
              length_high_next  = 1'b0;
              length_low_next   = 16'd0;
            end
          end else begin
            bytes_remaining_next = length_low_next;
            phase_next           = PH_BODY;
          end
        end else begin
          prefix_count_next = prefix_count + 2'd1;
        end
      end
      PH_BODY: begin
        tag = TAG_PATH + ((field_index > FIELD_TABLE) ? {1'b0, FIELD_TABLE}
                                                      : {1'b0, field_index});
        if (bytes_remaining != 16'd0) begin
          bytes_remaining_next = remaining_dec;
        end
        if (bytes_remaining_next == 16'd0) begin
          if (field_index >= FIELD_TABLE) begin
            phase_next = PH_TRAIL;
          end else begin
            field_index_next  = field_index + 2'd1;
            phase_next        = PH_PREFIX;
            prefix_count_next = 2'd0;
            length_high_next  = 1'b0;
            length_low_next   = 16'd0;
          end
        end
      end
      PH_TRAIL: begin
        tag = TAG_TRAILING;
      end
      default: begin
        tag        = TAG_REJECTED;
        phase_next = PH_REJECT;
      end
    endcase

    // The first error found is kept; the rest of the record is rejected.
    if (err != ERR_NONE) begin
      if (latched_error == ERR_NONE) begin
        latched_error_next = err;
      end
      phase_next = PH_REJECT;
    end

    result.field_tag   = tag;
    result.data_byte   = item.record_byte;
    result.is_create   = intent_create_next;
    result.record_done = item.last_byte;
    result.record_ok   = 1'b0;
    result.error_code  = ERR_NONE;

    // Verdict on the last byte, then back to the start of a record.
    if (item.last_byte) begin
      if (latched_error_next == ERR_NONE) begin
        if (phase_next == PH_PREFIX || phase_next == PH_BODY || phase_next == PH_INTENT) begin
          latched_error_next = ERR_TRUNCATED;
        end else if (phase_next == PH_TRAIL && path_was_empty_next) begin
          latched_error_next = ERR_EMPTY_PATH;
        end
      end
      result.error_code    = latched_error_next;
      result.record_ok     = (latched_error_next == ERR_NONE);
      phase_next           = PH_VERSION;
      field_index_next     = FIELD_PATH;
      prefix_count_next    = 2'd0;
      length_high_next     = 1'b0;
      length_low_next      = 16'd0;
      bytes_remaining_next = 16'd0;
      latched_error_next   = ERR_NONE;
      path_was_empty_next  = 1'b0;
      intent_create_next   = 1'b0;
    end
  end

  // Parse state advances once per accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_VERSION;
      field_index     <= FIELD_PATH;
      prefix_count    <= 2'd0;
      length_high     <= 1'b0;
      length_low      <= 16'd0;
      bytes_remaining <= 16'd0;
      latched_error   <= ERR_NONE;
      path_was_empty  <= 1'b0;
      intent_create   <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      field_index     <= field_index_next;
      prefix_count    <= prefix_count_next;
      length_high     <= length_high_next;
      length_low      <= length_low_next;
      bytes_remaining <= bytes_remaining_next;
      latched_error   <= latched_error_next;
      path_was_empty  <= path_was_empty_next;
      intent_create   <= intent_create_next;
    end
  end

endmodule

// ----- rtl/core/length_prefixed_record_parser.sv -----
// Top level of the length-prefixed record parser.
// Wraps lprp_core with the result register and a skid stage.
// Depends on lprp_pkg and lprp_core.
//
// Usage:
//   Record bytes arrive on the rec channel (rec_valid, rec_stall, rec_item),
//   one byte per transfer, with last_byte set on the final byte of a record.
//   Every byte produces exactly one result on the res channel (res_valid,
//   res_stall, res_item), tagged with its field; the result for the last byte
//   carries record_done, record_ok and the error code.
//   Throughput is one byte per cycle while the receiver does not stall,
//   set by the single parse step between the input and the result
//   register; records may follow each other with no gap.
//   When the receiver stalls, one more byte is taken into a skid register
//   and rec_stall then rises; it falls again once the result register drains.
//   Reset (rst, synchronous) empties both result stages, returns the parser
//   to the start of a record and loads the register defaults: version 1,
//   drop code 0, create code 1, maximum field length 65535.
//   The user writes the configuration port (cfg_write, cfg_index, cfg_data)
//   only while no record is in flight; the block itself does not enforce it.
module length_prefixed_record_parser import lprp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     rec_valid,
  output logic                     rec_stall,
  input  rec_item_t                rec_item,
  output logic                     res_valid,
  input  logic                     res_stall,
  output res_item_t                res_item
);

  logic      accept;
  logic      skid_valid;
  res_item_t skid_item;
  res_item_t new_result;

  // An input transfer happens when rec_valid is high and the skid stage is empty.
  assign rec_stall = skid_valid;
  assign accept    = rec_valid && !skid_valid;

  lprp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (rec_item),
    .result    (new_result)
  );

  // Result register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_item <= skid_item;
      end else if (accept) begin
        res_item <= new_result;
      end
    end else if (accept) begin
      skid_item <= new_result;
    end
  end

endmodule
